// ===== design/lhp_pkg.sv =====
// Shared types and constants for the 3x3 Laplacian edge filter.
// No dependencies; every other design file except lhp_ram imports this package.
`default_nettype none

package lhp_pkg;

  // Pixel component and result widths.
  localparam int PIX_W = 8;

  // Configuration register widths and the widest of them.
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 1;

  // Frame size limits and reset values.
  localparam int MIN_DIM       = 3;
  localparam int HEIGHT_LIMIT  = 4096;
  localparam int ROW_W         = 12;
  localparam int DEF_WIDTH     = 1024;
  localparam int DEF_HEIGHT    = 4096;
  localparam int DEF_MAX_WIDTH = 1024;

  // First row and column at which the whole window lies inside the image.
  localparam int WIN_START = 2;

  // Division by three as a multiplication by a rounded-up reciprocal.
  localparam int SUM_W      = 10;
  localparam int GRAY_RECIP = 2731;
  localparam int RECIP_W    = 12;
  localparam int GRAY_SHIFT = 13;
  localparam int PROD_W     = SUM_W + RECIP_W;

  // Result saturation limit.
  localparam int SAT_MAX = 255;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_t;

  // Input item: one RGB pixel.
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } in_pix_t;

  // Result item: one filtered pixel.
  typedef struct packed {
    logic [PIX_W-1:0] edge_value;
    logic             frame_last;
  } out_pix_t;

  // Control of the item held between the front end and the kernel stage.
  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
  } stage_ctl_t;

endpackage

`default_nettype wire

// ===== design/lhp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module lhp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/lhp_front.sv =====
// Front end: configuration registers, raster position counters, gray conversion,
// line store read issue and the clearing sweep after reset. Uses lhp_pkg.
`default_nettype none

module lhp_front #(
  parameter int MAX_WIDTH = lhp_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire lhp_pkg::in_pix_t                  in_data,
  input  wire logic                              cfg_we,
  input  wire logic [lhp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lhp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              s1_adv,
  output lhp_pkg::stage_ctl_t                    s1_ctl,
  output logic [lhp_pkg::PIX_W-1:0]              s1_gray,
  output logic [$clog2(MAX_WIDTH)-1:0]           s1_addr,
  output logic                                   ram_re,
  output logic [$clog2(MAX_WIDTH)-1:0]           ram_raddr,
  output logic                                   clearing,
  output logic [$clog2(MAX_WIDTH)-1:0]           clear_addr
);

  import lhp_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int EW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (EW > WIDTH_REG_W) ? EW : WIDTH_REG_W;
  localparam int RST_WIDTH = (DEF_WIDTH > MAX_WIDTH) ? MAX_WIDTH : DEF_WIDTH;

  logic [EW-1:0]           width_r, width_nxt;
  logic [HEIGHT_REG_W-1:0] height_r, height_nxt;
  logic [CW-1:0]           col_r, col_nxt;
  logic [ROW_W-1:0]        row_r, row_nxt;
  logic                    clear_r, clear_nxt;
  logic [CW-1:0]           clear_cnt_r, clear_cnt_nxt;
  stage_ctl_t              s1_ctl_r, s1_ctl_nxt;
  logic [PIX_W-1:0]        s1_gray_r;
  logic [CW-1:0]           s1_addr_r;

  logic [CMPW-1:0]         width_wr;
  logic [HEIGHT_REG_W-1:0] height_wr;
  logic                    accept;
  logic [EW-1:0]           col_ext;
  logic [HEIGHT_REG_W-1:0] row_ext;
  logic                    col_last, row_last, col_in, row_in, emit, last;
  logic [SUM_W-1:0]        pix_sum;
  logic [PROD_W-1:0]       gray_prod;
  logic [PIX_W-1:0]        gray;

  // Clamp written values into the supported frame size.
  assign width_wr  = CMPW'(cfg_data[WIDTH_REG_W-1:0]);
  assign height_wr = cfg_data[HEIGHT_REG_W-1:0];

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH: begin
          if (width_wr < CMPW'(MIN_DIM)) begin
            width_nxt = EW'(MIN_DIM);
          end else if (width_wr > CMPW'(MAX_WIDTH)) begin
            width_nxt = EW'(MAX_WIDTH);
          end else begin
            width_nxt = EW'(width_wr);
          end
        end
        CFG_IMAGE_HEIGHT: begin
          if (height_wr < HEIGHT_REG_W'(MIN_DIM)) begin
            height_nxt = HEIGHT_REG_W'(MIN_DIM);
          end else if (height_wr > HEIGHT_REG_W'(HEIGHT_LIMIT)) begin
            height_nxt = HEIGHT_REG_W'(HEIGHT_LIMIT);
          end else begin
            height_nxt = height_wr;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Line store clearing sweep, one entry per cycle after reset.
  always_comb begin
    clear_nxt     = clear_r;
    clear_cnt_nxt = clear_cnt_r;
    if (clear_r) begin
      clear_cnt_nxt = clear_cnt_r + CW'(1);
      if (clear_cnt_r == CW'(MAX_WIDTH - 1)) begin
        clear_nxt     = 1'b0;
        clear_cnt_nxt = '0;
      end
    end
  end

  // An item enters when no clearing sweep runs and the kernel stage is empty or moving on this cycle.
  assign in_ready = !clear_r && (!s1_ctl_r.valid || s1_adv);
  assign accept   = in_valid && in_ready;

  // Position decode against the current frame size.
  assign col_ext  = EW'(col_r);
  assign row_ext  = HEIGHT_REG_W'(row_r);
  assign col_last = (col_ext + EW'(1)) >= width_r;
  assign row_last = (row_ext + HEIGHT_REG_W'(1)) >= height_r;
  assign col_in   = col_ext < width_r;
  assign row_in   = row_ext < height_r;
  assign emit     = (row_r >= ROW_W'(WIN_START)) && (col_r >= CW'(WIN_START)) && row_in && col_in;
  assign last     = (row_ext == height_r - HEIGHT_REG_W'(1)) && (col_ext == width_r - EW'(1));

  // Gray level as the component sum divided by three.
  assign pix_sum   = SUM_W'(in_data.red) + SUM_W'(in_data.green) + SUM_W'(in_data.blue);
  assign gray_prod = PROD_W'(pix_sum) * PROD_W'(GRAY_RECIP);
  assign gray      = gray_prod[GRAY_SHIFT +: PIX_W];

  // Raster counters advance once per accepted item.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  // Kernel stage occupancy.
  always_comb begin
    s1_ctl_nxt = s1_ctl_r;
    if (accept) begin
      s1_ctl_nxt.valid = 1'b1;
      s1_ctl_nxt.emit  = emit;
      s1_ctl_nxt.last  = last;
    end else if (s1_adv) begin
      s1_ctl_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= EW'(RST_WIDTH);
      height_r    <= HEIGHT_REG_W'(DEF_HEIGHT);
      col_r       <= '0;
      row_r       <= '0;
      clear_r     <= 1'b1;
      clear_cnt_r <= '0;
      s1_ctl_r    <= '0;
    end else begin
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      clear_r     <= clear_nxt;
      clear_cnt_r <= clear_cnt_nxt;
      s1_ctl_r    <= s1_ctl_nxt;
    end
  end

  // Item payload into the kernel stage.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_gray_r <= gray;
      s1_addr_r <= col_r;
    end
  end

  assign s1_ctl     = s1_ctl_r;
  assign s1_gray    = s1_gray_r;
  assign s1_addr    = s1_addr_r;
  assign ram_re     = accept;
  assign ram_raddr  = col_r;
  assign clearing   = clear_r;
  assign clear_addr = clear_cnt_r;

  // No item enters while the line store is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_r |-> !in_ready)
    else $error("item accepted during line store clearing");

  // A result is only flagged for a column whose window is complete.
  a_emit_column: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_ctl_r.valid && s1_ctl_r.emit) |-> (s1_addr_r >= CW'(WIN_START)))
    else $error("result flagged at a border column");

  // An accepted item always occupies the kernel stage next cycle.
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_ctl_r.valid)
    else $error("accepted item lost before the kernel stage");

endmodule

`default_nettype wire

// ===== design/lhp_kernel.sv =====
// Kernel stage: 3x3 window registers, Laplacian sum with saturation, line store
// write-back and the result register. Uses lhp_pkg.
`default_nettype none

module lhp_kernel #(
  parameter int MAX_WIDTH = lhp_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire lhp_pkg::stage_ctl_t               s1_ctl,
  input  wire logic [lhp_pkg::PIX_W-1:0]         s1_gray,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]      s1_addr,
  input  wire logic [2*lhp_pkg::PIX_W-1:0]       ram_rdata,
  output logic                                   s1_adv,
  output logic                                   ram_we,
  output logic [$clog2(MAX_WIDTH)-1:0]           ram_waddr,
  output logic [2*lhp_pkg::PIX_W-1:0]            ram_wdata,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output lhp_pkg::out_pix_t                      out_data
);

  import lhp_pkg::*;

  localparam int ACC_W = PIX_W + 2;

  logic [PIX_W-1:0] win_top_r, win_mid_r, win_cur_r, win_left_r;
  logic             out_valid_r, out_valid_nxt;
  out_pix_t         out_data_r;

  logic [PIX_W-1:0] top, mid;
  logic [ACC_W-1:0] pos, neg, mag;
  logic [PIX_W-1:0] sat;

  // Line store read data: row r-2 in the upper half, row r-1 in the lower.
  assign top = ram_rdata[2*PIX_W-1:PIX_W];
  assign mid = ram_rdata[PIX_W-1:0];

  // Centre pixel, shifted left by two bits, against the sum of its top, bottom, left and right neighbours.
  assign pos = {win_mid_r, 2'b00};
  assign neg = ACC_W'(win_top_r) + ACC_W'(win_cur_r) + ACC_W'(win_left_r) + ACC_W'(mid);
  assign mag = (pos >= neg) ? (pos - neg) : (neg - pos);
  assign sat = (mag > ACC_W'(SAT_MAX)) ? PIX_W'(SAT_MAX) : mag[PIX_W-1:0];

  // The stage moves on unless a result is due and the output is still full.
  assign s1_adv = s1_ctl.valid && (!s1_ctl.emit || !out_valid_r || out_ready);

  // Line stores shift down by one row at this column.
  assign ram_we    = s1_adv;
  assign ram_waddr = s1_addr;
  assign ram_wdata = {mid, s1_gray};

  // Window shifts left by one column per item.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      win_top_r  <= top;
      win_mid_r  <= mid;
      win_cur_r  <= s1_gray;
      win_left_r <= win_mid_r;
    end
  end

  // Result register occupancy.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_ctl.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_ctl.emit) begin
      out_data_r.edge_value <= sat;
      out_data_r.frame_last <= s1_ctl.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A stalled stage leaves the pending result untouched.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_ctl.valid && !s1_adv) |=> (out_valid_r && $stable(out_data_r)))
    else $error("pending result changed while the kernel stage stalled");

  // The line store is only written for an item that is present.
  a_write_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> s1_ctl.valid)
    else $error("line store write without an item");

  // A result moving in always raises the output valid.
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_ctl.emit) |=> out_valid_r)
    else $error("result dropped on its way to the output");

endmodule

`default_nettype wire

// ===== design/laplacian_high_pass_3x3_core.sv =====
// Streaming 3x3 Laplacian edge filter: RGB in, saturated edge magnitude out.
// A result shows on out_valid once its pixel has passed the kernel stage register and the result register.
// Throughput: one pixel per cycle once the clearing sweep is done and while out_ready does not hold the output.
// Reset: synchronous active-low; afterwards all MAX_WIDTH line store entries are
// cleared with in_ready low, while configuration writes are taken.
// Top level; uses lhp_pkg, lhp_front, lhp_kernel and lhp_ram.
`default_nettype none

module laplacian_high_pass_3x3_core #(
  parameter int MAX_WIDTH = lhp_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire lhp_pkg::in_pix_t               in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output lhp_pkg::out_pix_t                   out_data,
  input  wire logic                           cfg_we,
  input  wire logic [lhp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lhp_pkg::CFG_DATA_W-1:0] cfg_data
);

  import lhp_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int LS_W  = 2 * PIX_W;

  stage_ctl_t       s1_ctl;
  logic [PIX_W-1:0] s1_gray;
  logic [CW-1:0]    s1_addr;
  logic             s1_adv;
  logic             rd_en;
  logic [CW-1:0]    rd_addr;
  logic [LS_W-1:0]  rd_data;
  logic             k_we;
  logic [CW-1:0]    k_waddr;
  logic [LS_W-1:0]  k_wdata;
  logic             clearing;
  logic [CW-1:0]    clear_addr;
  logic             ls_we;
  logic [CW-1:0]    ls_waddr;
  logic [LS_W-1:0]  ls_wdata;

  lhp_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s1_adv    (s1_adv),
    .s1_ctl    (s1_ctl),
    .s1_gray   (s1_gray),
    .s1_addr   (s1_addr),
    .ram_re    (rd_en),
    .ram_raddr (rd_addr),
    .clearing  (clearing),
    .clear_addr(clear_addr)
  );

  lhp_kernel #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_kernel (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_ctl    (s1_ctl),
    .s1_gray   (s1_gray),
    .s1_addr   (s1_addr),
    .ram_rdata (rd_data),
    .s1_adv    (s1_adv),
    .ram_we    (k_we),
    .ram_waddr (k_waddr),
    .ram_wdata (k_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The clearing sweep owns the write port until it finishes.
  assign ls_we    = clearing || k_we;
  assign ls_waddr = clearing ? clear_addr : k_waddr;
  assign ls_wdata = clearing ? '0 : k_wdata;

  // Both line stores share one entry per column.
  lhp_ram #(
    .WIDTH(LS_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk  (clk),
    .we   (ls_we),
    .waddr(ls_waddr),
    .wdata(ls_wdata),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // The kernel never writes back while the sweep is running.
  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !k_we)
    else $error("kernel write-back during line store clearing");

  // A read is never issued in the cycle its own column is written back.
  a_no_rw_same_col: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && k_we) |-> (rd_addr != k_waddr))
    else $error("line store read and write collide on one column");

  // Results only leave once the sweep has finished.
  a_out_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_valid)
    else $error("result shown during line store clearing");

endmodule

`default_nettype wire
